// ===== rtl/core/pwl_pkg.sv =====
`timescale 1ns / 1ps

package pwl_pkg;

    localparam int POINTS_DEF     = 32;
    localparam int CATEGORIES_DEF = 4;

    localparam int X_W   = 24;
    localparam int Y_W   = 16;
    localparam int E_W   = 16;
    localparam int S_W   = 12;
    localparam int CAT_W = 2;
    localparam int IDX_W = 5;
    localparam int CNT_W = 6;
    localparam int MASK_W = 4;

    localparam int ENTRY_W = X_W + Y_W + 2 * E_W;

    // input tdata layout, lowest bit up
    localparam int IN_DATA_W = 120;
    localparam int OFS_CAT   = 0;
    localparam int OFS_IDX   = 2;
    localparam int OFS_X     = 7;
    localparam int OFS_Y     = 31;
    localparam int OFS_EU    = 47;
    localparam int OFS_ED    = 63;
    localparam int OFS_PT    = 79;
    localparam int OFS_S     = 103;

    localparam logic signed [Y_W-1:0] ONE_Q12 = 16'sd4096;

    localparam int ADDR_W = 5;
    typedef enum logic [2:0] {
        REG_MASK = 3'd0,
        REG_PTS0 = 3'd1,
        REG_PTS1 = 3'd2,
        REG_PTS2 = 3'd3,
        REG_PTS3 = 3'd4
    } reg_idx_t;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_RD_LO,
        ST_RD_HI,
        ST_GET_HI,
        ST_MAC,
        ST_DIV_PREP,
        ST_DIV_CHK,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/core/piecewise_linear_weight_lookup.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_tvalid / s_tready       s_tdata (fields below), s_tuser = operation
// m_axis    out  m_tvalid / m_tready       m_tdata = weight, m_tuser = saturated
// apb       in   psel & penable & pwrite   paddr = 4*register, pwdata, prdata
//
// An evaluate item scans the breakpoints (one table read and one compare per breakpoint
// on the single read port), fetches the two bracketing points, then runs the shared
// multiplier, the overflow check and the bit-serial divider for a 16-bit quotient.
// A disabled category goes straight to the finish state.
// No clearing pass: reset clears only control.
// s_tready is low while an item is worked on; a result waiting on m_tready holds the
// finish state until the output register frees up.

module piecewise_linear_weight_lookup
    import pwl_pkg::*;
#(
    parameter int POINTS     = POINTS_DEF,
    parameter int CATEGORIES = CATEGORIES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // category[1:0], point_index[6:2], point_x[30:7], point_y[46:31],
    // point_err_up[62:47], point_err_down[78:63], query_pt[102:79],
    // shift_sigmas[114:103], zero fill above
    input  logic [IN_DATA_W-1:0] s_tdata,
    // operation[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // weight[15:0]
    output logic [15:0]          m_tdata,
    // saturated[0]
    output logic                 m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int DEPTH = CATEGORIES * POINTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(POINTS);
    localparam int IW    = $clog2(POINTS + 1);
    localparam int ACC_W = 56;
    localparam int PROD_W = 44;
    localparam int ENUM_W = 40;

    // ---------------- configuration ----------------
    logic [MASK_W-1:0] mask_reg;
    logic [CNT_W-1:0]  pts_reg [4];
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            for (int k = 0; k < 4; k++)
            begin
                pts_reg[k] <= CNT_W'(32);
            end
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MASK: mask_reg   <= pwdata[MASK_W-1:0];
                REG_PTS0: pts_reg[0] <= pwdata[CNT_W-1:0];
                REG_PTS1: pts_reg[1] <= pwdata[CNT_W-1:0];
                REG_PTS2: pts_reg[2] <= pwdata[CNT_W-1:0];
                REG_PTS3: pts_reg[3] <= pwdata[CNT_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_MASK: prdata = {{(32-MASK_W){1'b0}}, mask_reg};
            REG_PTS0: prdata = {{(32-CNT_W){1'b0}}, pts_reg[0]};
            REG_PTS1: prdata = {{(32-CNT_W){1'b0}}, pts_reg[1]};
            REG_PTS2: prdata = {{(32-CNT_W){1'b0}}, pts_reg[2]};
            REG_PTS3: prdata = {{(32-CNT_W){1'b0}}, pts_reg[3]};
            default:  prdata = '0;
        endcase
    end

    // ---------------- input fields ----------------
    logic [CAT_W-1:0] in_cat;
    logic [IDX_W-1:0] in_idx;
    logic [ENTRY_W-1:0] in_entry;
    logic             s_acc;

    assign in_cat   = s_tdata[OFS_CAT +: CAT_W];
    assign in_idx   = s_tdata[OFS_IDX +: IDX_W];
    // entry: x | y | err_up | err_down, x at the top
    assign in_entry = {s_tdata[OFS_X +: X_W], s_tdata[OFS_Y +: Y_W],
                       s_tdata[OFS_EU +: E_W], s_tdata[OFS_ED +: E_W]};
    assign s_acc    = s_tvalid & s_tready;

    // ---------------- breakpoint memory ----------------
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;

    assign wr_addr = AW'(32'(in_cat) * 32'(POINTS) + 32'(in_idx));
    assign wr_en   = s_acc && (s_tuser == OP_LOAD) && (32'(in_cat) < 32'(CATEGORIES))
                     && (32'(in_idx) < 32'(POINTS));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_entry;
        end
        rdata_reg <= mem[rd_addr];
    end

    logic [X_W-1:0]        rd_x;
    logic signed [Y_W-1:0] rd_y;
    logic [E_W-1:0]        rd_eu;
    logic [E_W-1:0]        rd_ed;

    assign rd_x  = rdata_reg[ENTRY_W-1 -: X_W];
    assign rd_y  = signed'(rdata_reg[2*E_W +: Y_W]);
    assign rd_eu = rdata_reg[E_W +: E_W];
    assign rd_ed = rdata_reg[0 +: E_W];

    // ---------------- sequencer and datapath registers ----------------
    state_t state_reg, state_next;
    logic [AW-1:0]         base_reg, base_next;
    logic [IW-1:0]         n_reg, n_next;
    logic [IW-1:0]         i_reg, i_next;
    logic [X_W-1:0]        pt_reg, pt_next;
    logic signed [S_W-1:0] s_reg, s_next;
    logic [X_W-1:0]        xl_reg, xl_next;
    logic signed [Y_W-1:0] yl_reg, yl_next, yh_reg, yh_next;
    logic [E_W-1:0]        el_reg, el_next, eh_reg, eh_next;
    logic [X_W-1:0]        d_reg, d_next, t_reg, t_next;
    logic [2:0]            k_reg, k_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [ENUM_W-1:0]     enum_reg, enum_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    logic                  over_reg, over_next;
    logic [ACC_W-1:0]      rem_reg, rem_next;
    logic [ACC_W-1:0]      dv_reg, dv_next;
    logic [15:0]           q_reg, q_next;
    logic [3:0]            dc_reg, dc_next;
    logic                  out_valid_reg, out_valid_next;
    logic [15:0]           weight_reg, weight_next;
    logic                  sat_reg, sat_next;

    // bracketing slots from the scan count
    logic [PW-1:0] lo_idx, hi_idx;
    always_comb
    begin
        priority if (i_reg == '0)
        begin
            lo_idx = '0;
            hi_idx = '0;
        end
        else if (i_reg == n_reg)
        begin
            lo_idx = PW'(i_reg - 1'b1);
            hi_idx = PW'(i_reg - 1'b1);
        end
        else
        begin
            lo_idx = PW'(i_reg - 1'b1);
            hi_idx = PW'(i_reg);
        end
    end

    // shared multiplier: signed 18 x unsigned 25
    logic signed [17:0] mul_a;
    logic [24:0]        mul_b;
    logic [X_W-1:0]     dmt;
    logic               pos_s;

    assign dmt   = d_reg - t_reg;
    assign pos_s = (s_reg > 0);

    always_comb
    begin
        unique case (k_reg)
            3'd0:    begin mul_a = signed'({2'b00, el_reg}); mul_b = {1'b0, dmt}; end
            3'd1:    begin mul_a = signed'({2'b00, eh_reg}); mul_b = {1'b0, t_reg}; end
            3'd2:    begin mul_a = 18'(yl_reg);              mul_b = {1'b0, dmt}; end
            3'd3:    begin mul_a = 18'(yh_reg);              mul_b = {1'b0, t_reg}; end
            3'd4:    begin mul_a = 18'(s_reg);  mul_b = {1'b0, enum_reg[23:0]}; end
            3'd5:    begin mul_a = 18'(s_reg);  mul_b = 25'(enum_reg[ENUM_W-1:24]); end
            default: begin mul_a = '0;          mul_b = '0; end
        endcase
    end

    logic signed [PROD_W-1:0] mul_p;
    assign mul_p = PROD_W'(mul_a * signed'({1'b0, mul_b}));

    // eval setup values
    logic [CNT_W-1:0] cnt_raw;
    logic [IW-1:0]    n_clamp;
    logic             cat_on;
    always_comb
    begin
        cnt_raw = pts_reg[in_cat];
        if (cnt_raw == '0)
        begin
            n_clamp = IW'(1);
        end
        else if (32'(cnt_raw) > 32'(POINTS))
        begin
            n_clamp = IW'(POINTS);
        end
        else
        begin
            n_clamp = IW'(cnt_raw);
        end
        cat_on = (32'(in_cat) < 32'(CATEGORIES)) && mask_reg[in_cat];
    end

    logic [31:0]      den;
    logic [ACC_W-1:0] acc_abs;
    assign den     = {d_reg, 8'd0};
    assign acc_abs = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    // read address
    always_comb
    begin
        unique case (state_reg)
            ST_RD_LO: rd_addr = base_reg + AW'(lo_idx);
            ST_RD_HI: rd_addr = base_reg + AW'(hi_idx);
            default:  rd_addr = base_reg + AW'(i_reg[PW-1:0]);
        endcase
    end

    // next state and datapath
    always_comb
    begin
        state_next = state_reg;
        base_next = base_reg;  n_next = n_reg;  i_next = i_reg;
        pt_next = pt_reg;      s_next = s_reg;  xl_next = xl_reg;
        yl_next = yl_reg;      yh_next = yh_reg;
        el_next = el_reg;      eh_next = eh_reg;
        d_next = d_reg;        t_next = t_reg;  k_next = k_reg;
        prod_next = prod_reg;  enum_next = enum_reg; acc_next = acc_reg;
        neg_next = neg_reg;    over_next = over_reg;
        rem_next = rem_reg;    dv_next = dv_reg; q_next = q_reg; dc_next = dc_reg;
        out_valid_next = out_valid_reg;
        weight_next = weight_reg;
        sat_next = sat_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && (s_tuser == OP_EVAL))
                begin
                    base_next = AW'(32'(in_cat) * 32'(POINTS));
                    n_next    = n_clamp;
                    i_next    = '0;
                    pt_next   = s_tdata[OFS_PT +: X_W];
                    s_next    = signed'(s_tdata[OFS_S +: S_W]);
                    if (cat_on)
                    begin
                        state_next = ST_SCAN_RD;
                    end
                    else
                    begin
                        neg_next  = 1'b0;
                        over_next = 1'b0;
                        q_next    = 16'(ONE_Q12);
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (pt_reg > rd_x)
                begin
                    i_next = i_reg + 1'b1;
                    state_next = (i_reg + 1'b1 == n_reg) ? ST_RD_LO : ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_RD_LO;
                end
            end
            ST_RD_LO:
            begin
                state_next = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                xl_next = rd_x;
                yl_next = rd_y;
                el_next = pos_s ? rd_eu : rd_ed;
                state_next = ST_GET_HI;
            end
            ST_GET_HI:
            begin
                yh_next = rd_y;
                eh_next = pos_s ? rd_eu : rd_ed;
                if (lo_idx == hi_idx || rd_x <= xl_reg)
                begin
                    d_next = X_W'(1);
                    t_next = '0;
                end
                else
                begin
                    d_next = rd_x - xl_reg;
                    t_next = pt_reg - xl_reg;
                end
                k_next    = '0;
                enum_next = '0;
                acc_next  = '0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                prod_next = mul_p;
                k_next = k_reg + 1'b1;
                unique case (k_reg)
                    3'd1, 3'd2: enum_next = enum_reg + ENUM_W'(prod_reg);
                    3'd3, 3'd4: acc_next = acc_reg + (ACC_W'(prod_reg) <<< 8);
                    3'd5:       acc_next = acc_reg + ACC_W'(prod_reg);
                    3'd6:       acc_next = acc_reg + (ACC_W'(prod_reg) <<< 24);
                    default:    ;
                endcase
                if (k_reg == 3'd6)
                begin
                    state_next = ST_DIV_PREP;
                end
            end
            ST_DIV_PREP:
            begin
                neg_next = acc_reg[ACC_W-1];
                rem_next = acc_abs + ACC_W'({d_reg, 7'd0});
                state_next = ST_DIV_CHK;
            end
            ST_DIV_CHK:
            begin
                over_next = (rem_reg >= ACC_W'({den, 16'd0}));
                dv_next   = ACC_W'({den, 15'd0});
                q_next    = '0;
                dc_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (rem_reg >= dv_reg)
                begin
                    rem_next = rem_reg - dv_reg;
                    q_next   = {q_reg[14:0], 1'b1};
                end
                else
                begin
                    q_next   = {q_reg[14:0], 1'b0};
                end
                dv_next = dv_reg >> 1;
                dc_next = dc_reg + 1'b1;
                if (dc_reg == 4'd15)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    if (neg_reg)
                    begin
                        if (over_reg || q_reg > 16'd32768)
                        begin
                            weight_next = 16'h8000;
                            sat_next    = 1'b1;
                        end
                        else
                        begin
                            weight_next = 16'(-q_reg);
                            sat_next    = 1'b0;
                        end
                    end
                    else
                    begin
                        if (over_reg || q_reg > 16'd32767)
                        begin
                            weight_next = 16'h7FFF;
                            sat_next    = 1'b1;
                        end
                        else
                        begin
                            weight_next = q_reg;
                            sat_next    = 1'b0;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = out_valid_reg;
        m_tdata  = weight_reg;
        m_tuser  = sat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            dc_reg        <= '0;
            i_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            dc_reg        <= dc_next;
            i_reg         <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;  n_reg <= n_next;
        pt_reg <= pt_next;      s_reg <= s_next;   xl_reg <= xl_next;
        yl_reg <= yl_next;      yh_reg <= yh_next;
        el_reg <= el_next;      eh_reg <= eh_next;
        d_reg <= d_next;        t_reg <= t_next;
        prod_reg <= prod_next;  enum_reg <= enum_next; acc_reg <= acc_next;
        neg_reg <= neg_next;    over_reg <= over_next;
        rem_reg <= rem_next;    dv_reg <= dv_next;  q_reg <= q_next;
        weight_reg <= weight_next;
        sat_reg <= sat_next;
    end

endmodule
